// ----- rtl/matrix_multiply_row_stream_defines.svh -----
// Assertion macros for the row-streaming matrix multiplier.
`ifndef MATRIX_MULTIPLY_ROW_STREAM_DEFINES_SVH
`define MATRIX_MULTIPLY_ROW_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger.
`define MMRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmrs same-cycle check failed");
// Check a condition in the cycle after its trigger.
`define MMRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmrs next-cycle check failed");
`else
`define MMRS_ASSERT_SAME(label, clk, rst, ante, cons)
`define MMRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/mmrs_pkg.sv -----
// Shared types and constants of the row-streaming matrix multiplier.
package mmrs_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int ACC_WIDTH       = 36;
   localparam int ROW_WIDTH       = 16;
   localparam int IDX_WIDTH       = 4;
   localparam int REG_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int MAX_DIM_DEF     = 16;

   localparam logic [REG_WIDTH-1:0] SIZE_RESET = REG_WIDTH'(16);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_STREAM = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INNER_SIZE = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_COLS   = CSR_INDEX_WIDTH'(1);

   typedef struct packed {
      logic                         cmd;
      logic [IDX_WIDTH-1:0]         inner_index;
      logic [IDX_WIDTH-1:0]         b_column;
      logic [ROW_WIDTH-1:0]         a_row;
      logic signed [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]        out_row;
      logic [IDX_WIDTH-1:0]        out_col;
      logic signed [ACC_WIDTH-1:0] result;
      logic                        last;
   } rsp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DRAIN
   } seq_state_type;

   // Per-cycle control from the sequencer to the MAC pipeline.
   typedef struct packed {
      logic issue;
      logic last_col;
      logic last_item;
   } ctl_type;

endpackage

// ----- rtl/mmrs_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module mmrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/mmrs_seq.sv -----
// Sequencer: accepts transactions, writes B loads and walks the columns of a row.
module mmrs_seq #(
   parameter int MAX_DIM = mmrs_pkg::MAX_DIM_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  mmrs_pkg::req_type                     req_item,
   input  logic [mmrs_pkg::REG_WIDTH-1:0]        inner_size,
   input  logic [mmrs_pkg::REG_WIDTH-1:0]        out_cols,
   input  logic                                  pipe_idle,
   output logic                                  busy,
   output logic                                  b_we,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_waddr,
   output logic [mmrs_pkg::DATA_WIDTH-1:0]       b_wdata,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    b_raddr,
   output logic [$clog2(MAX_DIM)-1:0]            col,
   output mmrs_pkg::ctl_type                     ctl,
   output logic signed [mmrs_pkg::DATA_WIDTH-1:0] a_value,
   output logic [mmrs_pkg::ROW_WIDTH-1:0]        a_row
);

   localparam int AW = $clog2(MAX_DIM*MAX_DIM);
   localparam int CW = $clog2(MAX_DIM);
   localparam int NW = $clog2(MAX_DIM+1);

   mmrs_pkg::seq_state_type state_ff, state_in;

   logic [CW-1:0]                         k_ff;
   logic [CW-1:0]                         col_ff, col_in;
   logic signed [mmrs_pkg::DATA_WIDTH-1:0] a_ff;
   logic [mmrs_pkg::ROW_WIDTH-1:0]        row_ff;
   logic                                  last_item_ff;

   logic [NW-1:0] n_inner;
   logic [NW-1:0] n_cols;
   logic          fire;
   logic          stream_go;
   logic          last_col;
   logic          issue;

   // Zero acts as one, anything above the array size saturates.
   function automatic logic [NW-1:0] eff_size(input logic [mmrs_pkg::REG_WIDTH-1:0] r);
      logic [NW-1:0] v;
      if (r == '0) begin
         v = NW'(1);
      end else if (32'(r) > MAX_DIM) begin
         v = NW'(MAX_DIM);
      end else begin
         v = NW'(r);
      end
      return v;
   endfunction

   assign n_inner   = eff_size(inner_size);
   assign n_cols    = eff_size(out_cols);
   assign fire      = start && !busy;
   assign stream_go = fire && (req_item.cmd == mmrs_pkg::CMD_STREAM)
                      && (32'(req_item.inner_index) < 32'(n_inner));
   assign last_col  = (32'(col_ff) == 32'(n_cols) - 32'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmrs_pkg::SEQ_IDLE: begin
            if (stream_go) begin
               state_in = mmrs_pkg::SEQ_RUN;
            end
         end
         mmrs_pkg::SEQ_RUN: begin
            if (last_col) begin
               state_in = mmrs_pkg::SEQ_DRAIN;
            end
         end
         mmrs_pkg::SEQ_DRAIN: begin
            if (pipe_idle) begin
               state_in = mmrs_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = mmrs_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      busy  = 1'b1;
      issue = 1'b0;
      case (state_ff)
         mmrs_pkg::SEQ_IDLE: begin
            busy = 1'b0;
         end
         mmrs_pkg::SEQ_RUN: begin
            issue = 1'b1;
         end
         mmrs_pkg::SEQ_DRAIN: begin
            issue = 1'b0;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_comb begin
      col_in = col_ff;
      if (stream_go) begin
         col_in = '0;
      end else if (issue) begin
         col_in = col_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmrs_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the stream element for the whole row walk.
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      if (stream_go) begin
         k_ff         <= CW'(req_item.inner_index);
         a_ff         <= req_item.value;
         row_ff       <= req_item.a_row;
         last_item_ff <= (32'(req_item.inner_index) == 32'(n_inner) - 32'd1);
      end
   end

   // Loads outside the store are dropped.
   assign b_we    = fire && (req_item.cmd == mmrs_pkg::CMD_LOAD)
                    && (32'(req_item.inner_index) < MAX_DIM)
                    && (32'(req_item.b_column) < MAX_DIM);
   assign b_waddr = AW'(32'(req_item.inner_index) * MAX_DIM + 32'(req_item.b_column));
   assign b_wdata = req_item.value;
   assign b_raddr = AW'(32'(k_ff) * MAX_DIM + 32'(col_ff));

   assign col           = col_ff;
   assign ctl.issue     = issue;
   assign ctl.last_col  = last_col;
   assign ctl.last_item = last_item_ff;
   assign a_value       = a_ff;
   assign a_row         = row_ff;

endmodule

// ----- rtl/mmrs_mac.sv -----
// Multiply-accumulate pipeline: product, sum update, write-back and result register.
module mmrs_mac #(
   parameter int MAX_DIM = mmrs_pkg::MAX_DIM_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mmrs_pkg::ctl_type                      ctl,
   input  logic [$clog2(MAX_DIM)-1:0]             col,
   input  logic signed [mmrs_pkg::DATA_WIDTH-1:0] a_value,
   input  logic [mmrs_pkg::ROW_WIDTH-1:0]         a_row,
   input  logic [mmrs_pkg::DATA_WIDTH-1:0]        b_rdata,
   input  logic [mmrs_pkg::ACC_WIDTH-1:0]         sum_rdata,
   output logic                                   sum_we,
   output logic [$clog2(MAX_DIM)-1:0]             sum_waddr,
   output logic [mmrs_pkg::ACC_WIDTH-1:0]         sum_wdata,
   output logic                                   pipe_idle,
   output logic                                   rsp_valid,
   output mmrs_pkg::rsp_type                      rsp_item
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int PW = 2 * mmrs_pkg::DATA_WIDTH;

   // Entries not written since the last row close read as zero.
   logic [MAX_DIM-1:0] sum_ok_ff;

   logic          s1_vld_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_last_col_ff;
   logic          s1_last_item_ff;
   logic          s1_ok_ff;

   logic                                  s2_vld_ff;
   logic [CW-1:0]                         s2_col_ff;
   logic                                  s2_last_col_ff;
   logic                                  s2_last_item_ff;
   logic signed [PW-1:0]                  s2_prod_ff;
   logic [mmrs_pkg::ACC_WIDTH-1:0]        s2_sum_ff;

   logic signed [PW-1:0]            prod_in;
   logic [mmrs_pkg::ACC_WIDTH-1:0]  sum_in;
   logic                            rsp_valid_ff;
   mmrs_pkg::rsp_type               rsp_item_ff;

   assign prod_in = a_value * $signed(b_rdata);
   assign sum_in  = s2_sum_ff + mmrs_pkg::ACC_WIDTH'(s2_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ok_ff    <= '0;
      end else begin
         s1_vld_ff    <= ctl.issue;
         s2_vld_ff    <= s1_vld_ff;
         rsp_valid_ff <= s2_vld_ff && s2_last_item_ff;
         if (s2_vld_ff && s2_last_item_ff && s2_last_col_ff) begin
            sum_ok_ff <= '0;
         end else if (sum_we) begin
            sum_ok_ff[s2_col_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff       <= col;
      s1_last_col_ff  <= ctl.last_col;
      s1_last_item_ff <= ctl.last_item;
      s1_ok_ff        <= sum_ok_ff[col];

      s2_col_ff       <= s1_col_ff;
      s2_last_col_ff  <= s1_last_col_ff;
      s2_last_item_ff <= s1_last_item_ff;
      s2_prod_ff      <= prod_in;
      s2_sum_ff       <= s1_ok_ff ? sum_rdata : '0;

      rsp_item_ff.out_row <= a_row;
      rsp_item_ff.out_col <= mmrs_pkg::IDX_WIDTH'(s2_col_ff);
      rsp_item_ff.result  <= sum_in;
      rsp_item_ff.last    <= s2_last_col_ff;
   end

   // The closing element emits its sums instead of writing them back.
   assign sum_we    = s2_vld_ff && !s2_last_item_ff;
   assign sum_waddr = s2_col_ff;
   assign sum_wdata = sum_in;
   assign pipe_idle = !s1_vld_ff && !s2_vld_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- rtl/matrix_multiply_row_stream.sv -----
// Row-streaming matrix multiplier top level: registers, B store, sum store and pipeline.
// A load, or a stream element whose inner index is at or past the effective inner_size, leaves busy low.
// Any other stream element keeps busy high through the column run and the pipeline drain,
// set by the single read port of the B store feeding one shared multiplier, a column a cycle.
// On the closing element of a row, results follow in column order.
// Reset clears the sums and sets both sizes to 16; the B store is undefined until loaded.
`include "matrix_multiply_row_stream_defines.svh"
module matrix_multiply_row_stream #(
   parameter int MAX_DIM = mmrs_pkg::MAX_DIM_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mmrs_pkg::req_type                    req_item,
   output logic                                 rsp_valid,
   output mmrs_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_we,
   input  logic [mmrs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mmrs_pkg::REG_WIDTH-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_DIM*MAX_DIM);
   localparam int CW = $clog2(MAX_DIM);

   logic [mmrs_pkg::REG_WIDTH-1:0] inner_size_ff, inner_size_in;
   logic [mmrs_pkg::REG_WIDTH-1:0] out_cols_ff, out_cols_in;

   logic                                   b_we;
   logic [AW-1:0]                          b_waddr;
   logic [mmrs_pkg::DATA_WIDTH-1:0]        b_wdata;
   logic [AW-1:0]                          b_raddr;
   logic [mmrs_pkg::DATA_WIDTH-1:0]        b_rdata;
   logic [CW-1:0]                          col;
   mmrs_pkg::ctl_type                      ctl;
   logic signed [mmrs_pkg::DATA_WIDTH-1:0] a_value;
   logic [mmrs_pkg::ROW_WIDTH-1:0]         a_row;
   logic                                   sum_we;
   logic [CW-1:0]                          sum_waddr;
   logic [mmrs_pkg::ACC_WIDTH-1:0]         sum_wdata;
   logic [mmrs_pkg::ACC_WIDTH-1:0]         sum_rdata;
   logic                                   pipe_idle;

   always_comb begin
      inner_size_in = inner_size_ff;
      out_cols_in   = out_cols_ff;
      if (csr_we) begin
         case (csr_index)
            mmrs_pkg::CSR_INNER_SIZE: inner_size_in = csr_wdata;
            mmrs_pkg::CSR_OUT_COLS:   out_cols_in   = csr_wdata;
            default: begin
               inner_size_in = inner_size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_size_ff <= mmrs_pkg::SIZE_RESET;
         out_cols_ff   <= mmrs_pkg::SIZE_RESET;
      end else begin
         inner_size_ff <= inner_size_in;
         out_cols_ff   <= out_cols_in;
      end
   end

   mmrs_seq #(
      .MAX_DIM(MAX_DIM)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .inner_size (inner_size_ff),
      .out_cols   (out_cols_ff),
      .pipe_idle  (pipe_idle),
      .busy       (busy),
      .b_we       (b_we),
      .b_waddr    (b_waddr),
      .b_wdata    (b_wdata),
      .b_raddr    (b_raddr),
      .col        (col),
      .ctl        (ctl),
      .a_value    (a_value),
      .a_row      (a_row)
   );

   mmrs_ram #(
      .WIDTH(mmrs_pkg::DATA_WIDTH),
      .DEPTH(MAX_DIM*MAX_DIM)
   ) u_b_store (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   mmrs_ram #(
      .WIDTH(mmrs_pkg::ACC_WIDTH),
      .DEPTH(MAX_DIM)
   ) u_row_sums (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .raddr (col),
      .rdata (sum_rdata)
   );

   mmrs_mac #(
      .MAX_DIM(MAX_DIM)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .col       (col),
      .a_value   (a_value),
      .a_row     (a_row),
      .b_rdata   (b_rdata),
      .sum_rdata (sum_rdata),
      .sum_we    (sum_we),
      .sum_waddr (sum_waddr),
      .sum_wdata (sum_wdata),
      .pipe_idle (pipe_idle),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Results only come out of a row walk that was under way.
   `MMRS_ASSERT_SAME(a_rsp_from_walk, clock, reset, rsp_valid, $past(busy))
   // A load never starts a row walk.
   `MMRS_ASSERT_NEXT(a_load_stays_idle, clock, reset, start && !busy && req_item.cmd == mmrs_pkg::CMD_LOAD, !busy)
   // Columns of one row leave back to back.
   `MMRS_ASSERT_NEXT(a_rsp_contiguous, clock, reset, rsp_valid && !rsp_item.last, rsp_valid)
   // Nothing follows the closing column in the next cycle.
   `MMRS_ASSERT_NEXT(a_rsp_last_ends, clock, reset, rsp_valid && rsp_item.last, !rsp_valid)

endmodule
